@@ rtl/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

  // default list depth
  localparam int CAPACITY_DEF = 32;

  // field widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int IN_W   = 48;

  // position and length compare width, covers every capacity up to 64
  localparam int CMP_W = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_ELEM       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_INSERT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_REMOVE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL       = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // control broadcast to every cell
  typedef struct packed {
    cell_op_t         op;
    logic [CMP_W-1:0] len;
    logic [CMP_W-1:0] pos;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/ple_cell.sv @@
`default_nettype none

module ple_cell #(
  parameter int IDX = 0
) (
  input  wire logic                    clk,
  input  wire ple_pkg::cell_ctl_t      ctl,
  input  wire logic [ple_pkg::VAL_W-1:0] value,
  input  wire logic [ple_pkg::VAL_W-1:0] left_data,
  input  wire logic [ple_pkg::VAL_W-1:0] right_data,
  input  wire logic [ple_pkg::VAL_W-1:0] head_data,
  output logic      [ple_pkg::VAL_W-1:0] data
);

  localparam logic [ple_pkg::CMP_W-1:0] MY_IDX  = ple_pkg::CMP_W'(IDX);
  localparam logic [ple_pkg::CMP_W-1:0] MY_NEXT = ple_pkg::CMP_W'(IDX + 1);

  logic [ple_pkg::CMP_W-1:0] pos_m1;
  logic [ple_pkg::CMP_W-1:0] len_m1;
  logic [ple_pkg::VAL_W-1:0] data_next;

  assign pos_m1 = ctl.pos - 1'b1;
  assign len_m1 = ctl.len - 1'b1;

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      ple_pkg::OP_LOAD: begin
        if (MY_IDX == ctl.len) data_next = value;
      end
      ple_pkg::OP_INSERT: begin
        if (MY_IDX == pos_m1) data_next = value;
        else if (MY_IDX > pos_m1 && MY_IDX <= ctl.len) data_next = left_data;
      end
      ple_pkg::OP_REMOVE: begin
        if (MY_IDX >= pos_m1 && MY_NEXT < ctl.len) data_next = right_data;
      end
      ple_pkg::OP_ROTATE: begin
        if (MY_NEXT < ctl.len) data_next = right_data;
        else if (MY_IDX == len_m1) data_next = head_data;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

@@ rtl/positional_list_editor.sv @@
`default_nettype none

// Positional list editor: keeps an ordered list of up to CAPACITY signed 32-bit
// values in a row of cells, one entry per cell, and edits it by 1-based
// position. A load (command 0) appends at the end and returns nothing; an
// insert (command 1) at a position from 1 to length+1 and a remove (command 2)
// at a position from 1 to length each return the whole list afterwards, one
// element per transfer in order, tlast on the final one (nothing if the list
// ends up empty). A bad position returns one status transfer (1 for insert,
// 2 for remove); a load or valid insert into a full list returns status 3.
// Command 3 is ignored. Timing: a command is taken only while idle with the
// output register free, and the cells shift in the same cycle; the readout after
// an insert or remove then rotates the list one cell per cycle through the head
// cell while the output register is free, and no next command is taken until
// the readout ends, while loads and status results leave the block idle. Output
// back-pressure stalls the readout.
module positional_list_editor #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF  // 2 to 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // command[1:0], position[8:2], value[40:9], zero pad
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // element[31:0]
  output logic [1:0]       m_tuser,   // status[1:0]
  output logic             m_tlast
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam logic [ple_pkg::CMP_W-1:0] CAP_C = ple_pkg::CMP_W'(CAPACITY);

  // input fields
  logic [ple_pkg::CMD_W-1:0] cmd;
  logic [ple_pkg::POS_W-1:0] pos;
  logic [ple_pkg::VAL_W-1:0] value;

  assign cmd   = s_tdata[1:0];
  assign pos   = s_tdata[8:2];
  assign value = s_tdata[40:9];

  // control state
  ple_pkg::state_t state, state_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] cnt, cnt_next;

  // output register
  logic                       out_load;
  logic [ple_pkg::STAT_W-1:0] out_status;
  logic [ple_pkg::VAL_W-1:0]  out_elem;
  logic                       out_last;
  logic                       out_free;

  ple_pkg::cell_ctl_t ctl;

  logic [ple_pkg::VAL_W-1:0] cell_q [CAPACITY];

  logic [ple_pkg::CMP_W-1:0] len_c;
  logic [ple_pkg::CMP_W-1:0] len_m1_c;
  logic                      full;
  logic                      accept;

  assign len_c    = ple_pkg::CMP_W'(len);
  assign len_m1_c = len_c - 1'b1;
  assign full     = (len_c == CAP_C);
  assign out_free = !m_tvalid || m_tready;
  // no command is taken while reset is held
  assign s_tready = !rst && (state == ple_pkg::ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::ST_IDLE;
      len   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
      cnt   <= cnt_next;
    end
  end

  // next state, cell commands and result selection
  always_comb begin
    state_next = state;
    len_next   = len;
    cnt_next   = cnt;
    ctl.op     = ple_pkg::OP_HOLD;
    ctl.len    = len_c;
    ctl.pos    = pos;
    out_load   = 1'b0;
    out_status = ple_pkg::STAT_ELEM;
    out_elem   = '0;
    out_last   = 1'b1;
    unique case (state)
      ple_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            ple_pkg::CMD_LOAD: begin
              if (full) begin
                out_load   = 1'b1;
                out_status = ple_pkg::STAT_FULL;
              end else begin
                ctl.op   = ple_pkg::OP_LOAD;
                len_next = len + 1'b1;
              end
            end
            ple_pkg::CMD_INSERT: begin
              // position check comes before the fullness check
              if (pos == '0 || pos > len_c + 1'b1) begin
                out_load   = 1'b1;
                out_status = ple_pkg::STAT_BAD_INSERT;
              end else if (full) begin
                out_load   = 1'b1;
                out_status = ple_pkg::STAT_FULL;
              end else begin
                ctl.op     = ple_pkg::OP_INSERT;
                len_next   = len + 1'b1;
                cnt_next   = '0;
                state_next = ple_pkg::ST_EMIT;
              end
            end
            ple_pkg::CMD_REMOVE: begin
              if (pos == '0 || pos > len_c) begin
                out_load   = 1'b1;
                out_status = ple_pkg::STAT_BAD_REMOVE;
              end else begin
                ctl.op   = ple_pkg::OP_REMOVE;
                len_next = len - 1'b1;
                cnt_next = '0;
                // emptied list gives no readout
                if (len_c != ple_pkg::CMP_W'(1)) state_next = ple_pkg::ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ple_pkg::ST_EMIT: begin
        // head cell goes out, the row rotates by one
        if (out_free) begin
          ctl.op   = ple_pkg::OP_ROTATE;
          out_load = 1'b1;
          out_elem = cell_q[0];
          out_last = (ple_pkg::CMP_W'(cnt) == len_m1_c);
          cnt_next = cnt + 1'b1;
          if (out_last) state_next = ple_pkg::ST_IDLE;
        end
      end
      default: state_next = ple_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= out_status;
      m_tdata <= out_elem;
      m_tlast <= out_last;
    end
  end

  // row of cells, each linked to both neighbors and to the head for the wrap
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ple_pkg::VAL_W-1:0] left_d;
    logic [ple_pkg::VAL_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[0];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    ple_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .data       (cell_q[i])
    );
  end

`ifndef SYNTH
  // length never runs past the number of cells
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    ple_pkg::CMP_W'(len) <= CAP_C)
    else $error("list length exceeds capacity");

  // no command is taken while the list is being read out
  a_no_accept_emit: assert property (@(posedge clk) disable iff (rst)
    state == ple_pkg::ST_EMIT |-> !s_tready)
    else $error("command accepted during readout");

  // readout ends exactly after the element marked last
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (state == ple_pkg::ST_EMIT && out_load && out_last) |=> state == ple_pkg::ST_IDLE)
    else $error("readout did not finish after last element");

  // readout never starts with an empty list
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ple_pkg::ST_EMIT |-> len != '0)
    else $error("readout with empty list");
`endif

endmodule

`default_nettype wire

@@ verif/positional_list_editor_test.sv @@
`timescale 1ns / 1ps

module positional_list_editor_test;

  typedef logic [ple_pkg::CMD_W-1:0]  cmd_t;
  typedef logic [ple_pkg::POS_W-1:0]  pos_t;
  typedef logic [ple_pkg::VAL_W-1:0]  val_t;
  typedef logic [ple_pkg::STAT_W-1:0] stat_t;

  localparam int LIST_DEPTH = ple_pkg::CAPACITY_DEF;
  localparam int RANDOM_EDITS = 220;
  localparam int CYCLE_LIMIT = 400000;
  // readout of a full list plus margin
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  // the spare command code, which the block drops
  localparam cmd_t CMD_IGNORED = 2'd3;

  typedef struct packed {
    stat_t status;
    val_t  element;
    logic  last;
  } list_result_t;

  // shadow copy of the list plus the queue of result transfers still owed
  class list_scoreboard;
    val_t         shadow_list[$];
    list_result_t owed_results[$];
    int failures;
    int results_seen;
    int listings;
    int status_seen;
    int deepest;

    function int length_now();
      return shadow_list.size();
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    function void owe_result(list_result_t r);
      owed_results = {owed_results, r};
    endfunction

    function void push_status(stat_t code);
      list_result_t r;
      r.status  = code;
      r.element = '0;
      r.last    = 1'b1;
      owe_result(r);
      status_seen++;
    endfunction

    // whole list in order, last flag on the tail entry, nothing when empty
    function void push_listing();
      list_result_t r;
      foreach (shadow_list[k]) begin
        r.status  = ple_pkg::STAT_ELEM;
        r.element = shadow_list[k];
        r.last    = (k == shadow_list.size() - 1);
        owe_result(r);
      end
      listings++;
      if (shadow_list.size() > deepest) deepest = shadow_list.size();
    endfunction

    function void note_command(cmd_t cmd, pos_t pos, val_t val);
      int len;
      int idx;
      len = shadow_list.size();
      idx = int'(pos) - 1;
      case (cmd)
        ple_pkg::CMD_LOAD: begin
          if (len >= LIST_DEPTH) push_status(ple_pkg::STAT_FULL);
          else shadow_list = {shadow_list, val};
        end
        ple_pkg::CMD_INSERT: begin
          // position is checked before fullness
          if (pos == 0 || int'(pos) > len + 1) push_status(ple_pkg::STAT_BAD_INSERT);
          else if (len >= LIST_DEPTH) push_status(ple_pkg::STAT_FULL);
          else begin
            shadow_list.insert(idx, val);
            push_listing();
          end
        end
        ple_pkg::CMD_REMOVE: begin
          if (pos == 0 || int'(pos) > len) push_status(ple_pkg::STAT_BAD_REMOVE);
          else begin
            shadow_list.delete(idx);
            push_listing();
          end
        end
        default: ;
      endcase
      if (shadow_list.size() > deepest) deepest = shadow_list.size();
    endfunction

    function void check_result(stat_t status, val_t element, logic last);
      list_result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result transfer: status %0d element %0d last %0b",
               status, $signed(element), last);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      results_seen++;
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, status);
        failures++;
      end
      if (element !== want.element) begin
        $error("element mismatch: expected %0d, got %0d",
               $signed(want.element), $signed(element));
        failures++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, got %0b", want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [ple_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  val_t                      m_tdata;
  stat_t                     m_tuser;
  logic                      m_tlast;

  list_scoreboard sb = new();

  int cycle_count = 0;
  int burst_left = 0;
  int edits_sent = 0;
  int ready_span = 0;
  int ready_mode = 0;

  always #6 clk = ~clk;

  positional_list_editor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // command[1:0], position[8:2], value[40:9], zero pad
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // element[31:0]
    .m_tuser  (m_tuser),   // status[1:0]
    .m_tlast  (m_tlast)
  );

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("positional_list_editor regression: fail");
      $finish;
    end
  end

  // receiver back-pressure: switches between a few stall styles every so often,
  // always-ready stretches included
  always @(negedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_span <= $urandom_range(16, 96);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (ready_span[2:0] < 5);
    endcase
  end

  // result monitor, every transfer goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  // mostly random words, sometimes the extremes
  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // one command transfer; valid stays high across a burst, drops for the gaps
  task automatic send_command(input cmd_t cmd, input pos_t pos, input val_t val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(ple_pkg::IN_W - ple_pkg::CMD_W - ple_pkg::POS_W - ple_pkg::VAL_W){1'b0}},
                 val, pos, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, pos, val);
    burst_left--;
    edits_sent++;
  endtask

  initial begin
    int len;
    int target;
    int steps;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: bad positions on an empty list, edits at both ends, extreme values
    send_command(ple_pkg::CMD_REMOVE, 7'd1, 32'h0);
    send_command(ple_pkg::CMD_INSERT, 7'd0, 32'h1234_5678);
    send_command(ple_pkg::CMD_INSERT, 7'd2, 32'h1234_5678);
    send_command(ple_pkg::CMD_INSERT, 7'd1, 32'h8000_0000);
    send_command(ple_pkg::CMD_LOAD, 7'd0, 32'h7fff_ffff);
    send_command(ple_pkg::CMD_LOAD, 7'd127, 32'h0);
    send_command(ple_pkg::CMD_LOAD, 7'd0, 32'hffff_ffff);
    send_command(ple_pkg::CMD_INSERT, 7'd5, 32'h0000_0001);    // append through insert
    send_command(ple_pkg::CMD_INSERT, 7'd3, 32'h5555_5555);    // middle
    send_command(ple_pkg::CMD_REMOVE, 7'd6, 32'hffff_ffff);    // tail entry
    send_command(ple_pkg::CMD_REMOVE, 7'd1, 32'h0);            // head entry
    send_command(ple_pkg::CMD_REMOVE, 7'd127, 32'h0);
    send_command(ple_pkg::CMD_INSERT, 7'd127, 32'haaaa_aaaa);
    send_command(CMD_IGNORED, 7'd127, 32'hffff_ffff);
    // empty it from the front, the final remove returns nothing
    while (sb.length_now() > 0) send_command(ple_pkg::CMD_REMOVE, 7'd1, pick_value());
    send_command(CMD_IGNORED, 7'd0, 32'h0);

    // random episodes until enough commands went in
    while (edits_sent < RANDOM_EDITS) begin
      case ($urandom_range(0, 9))
        7: begin
          // fill to capacity, hit the full and bad-position cases, then one remove and one insert
          while (sb.length_now() < LIST_DEPTH)
            send_command(ple_pkg::CMD_LOAD, pos_t'($urandom()), pick_value());
          len = sb.length_now();
          send_command(ple_pkg::CMD_LOAD, pos_t'($urandom()), pick_value());
          send_command(ple_pkg::CMD_INSERT, pos_t'($urandom_range(1, len + 1)), pick_value());
          send_command(ple_pkg::CMD_INSERT, pos_t'($urandom_range(len + 2, 127)),
                       pick_value());
          send_command(ple_pkg::CMD_INSERT, 7'd0, pick_value());
          send_command(ple_pkg::CMD_REMOVE, pos_t'($urandom_range(1, len)), pick_value());
          send_command(ple_pkg::CMD_INSERT, pos_t'($urandom_range(1, len)), pick_value());
        end
        8: begin
          // drain down to a small list, sometimes to empty
          target = $urandom_range(0, 3);
          while (sb.length_now() > target)
            send_command(ple_pkg::CMD_REMOVE, pos_t'($urandom_range(1, sb.length_now())),
                         pick_value());
        end
        9: begin
          // noise and broken positions over the whole field range
          steps = $urandom_range(2, 8);
          repeat (steps) begin
            len = sb.length_now();
            case ($urandom_range(0, 3))
              0: send_command(ple_pkg::CMD_INSERT, (len + 2 > 127) ? 7'd0 :
                              pos_t'($urandom_range(len + 2, 127)), pick_value());
              1: send_command(ple_pkg::CMD_REMOVE, pos_t'($urandom_range(len + 1, 127)),
                              pick_value());
              2: send_command($urandom_range(0, 1) ? ple_pkg::CMD_INSERT :
                              ple_pkg::CMD_REMOVE, 7'd0, pick_value());
              default: send_command(cmd_t'($urandom()), pos_t'($urandom()), $urandom());
            endcase
          end
        end
        default: begin
          // well-formed edits with random content, now and then the spare command
          steps = $urandom_range(3, 12);
          repeat (steps) begin
            len = sb.length_now();
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4: send_command(ple_pkg::CMD_LOAD, pos_t'($urandom()), pick_value());
              5, 6, 7, 8, 9, 10, 11:
                send_command(ple_pkg::CMD_INSERT, pos_t'($urandom_range(1, len + 1)),
                             pick_value());
              19: send_command(CMD_IGNORED, pos_t'($urandom()), $urandom());
              default: begin
                if (len > 0)
                  send_command(ple_pkg::CMD_REMOVE, pos_t'($urandom_range(1, len)),
                               pick_value());
                else send_command(ple_pkg::CMD_INSERT, 7'd1, pick_value());
              end
            endcase
          end
        end
      endcase
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    // any stray transfer after the last owed one is caught by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d result transfers: %0d listings, %0d status codes",
             sb.results_seen, sb.listings, sb.status_seen);
    $display("longest list %0d of %0d entries, %0d commands, %0d cycles", sb.deepest,
             LIST_DEPTH, edits_sent, cycle_count);
    if (sb.failures == 0 && sb.owed() == 0) begin
      $display("positional_list_editor regression: pass");
    end else begin
      $display("positional_list_editor regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_editor.sv
verif/positional_list_editor_test.sv
